>>> src/brr_pkg.sv
`default_nettype none
package brr_pkg;

  localparam int NPROC_DEF   = 8;
  localparam int NRES_DEF    = 4;
  localparam int COUNT_W_DEF = 8;
  localparam int NRES_PORTS  = 4;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_REQUEST = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;

  localparam logic [3:0] ST_STARTED  = 4'd0;
  localparam logic [3:0] ST_LOADED   = 4'd1;
  localparam logic [3:0] ST_GRANTED  = 4'd2;
  localparam logic [3:0] ST_REFUSED  = 4'd3;
  localparam logic [3:0] ST_OVERNEED = 4'd4;
  localparam logic [3:0] ST_SHORT    = 4'd5;
  localparam logic [3:0] ST_UNSAFE   = 4'd6;
  localparam logic [3:0] ST_RELEASED = 4'd7;
  localparam logic [3:0] ST_QUERY    = 4'd8;

endpackage
`default_nettype wire

>>> src/brr_row_mem.sv
`default_nettype none
module brr_row_mem #(
  parameter int DEPTH = brr_pkg::NPROC_DEF,
  parameter int WIDTH = 16,
  parameter int AW    = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clear,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [WIDTH-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // rows never written since start read as zero
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      rvalid_q <= row_valid[raddr];
    end
  end

  assign rdata = rvalid_q ? rdata_q : '0;

endmodule
`default_nettype wire

>>> src/bankers_request_release_unit.sv
`default_nettype none
// Banker's allocator for NPROC processes and NRES resource types. Per-process maxima,
// allocation, need and pending request live in one row memory read one row per cycle.
// Start and query go from idle straight to the finish states; load reads and rewrites
// its row first. A granted-on-trial request runs a safety walk of at most NPROC+1 passes
// over the rows, each row read and, unless already done, checked; a release repeats
// that walk for every waiting process it retries. A result is held in an output
// register while the next request may already be taken.
module bankers_request_release_unit #(
  parameter int NPROC   = brr_pkg::NPROC_DEF,
  parameter int NRES    = brr_pkg::NRES_DEF,
  parameter int COUNT_W = brr_pkg::COUNT_W_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] op,
  input  wire logic [2:0] proc,
  input  wire logic [7:0] amount_0,
  input  wire logic [7:0] amount_1,
  input  wire logic [7:0] amount_2,
  input  wire logic [7:0] amount_3,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      status,
  output logic [7:0]      waiting_mask,
  output logic [3:0]      release_refused_mask,
  output logic [7:0]      avail_0,
  output logic [7:0]      avail_1,
  output logic [7:0]      avail_2,
  output logic [7:0]      avail_3,
  output logic [7:0]      proc_alloc_0,
  output logic [7:0]      proc_alloc_1,
  output logic [7:0]      proc_alloc_2,
  output logic [7:0]      proc_alloc_3
);

  localparam int PW = (NPROC > 1) ? $clog2(NPROC) : 1;
  localparam int CW = $clog2(NPROC + 1);
  localparam int WW = COUNT_W + CW;
  localparam logic [COUNT_W-1:0] CMAX = {COUNT_W{1'b1}};

  typedef logic [NRES-1:0][COUNT_W-1:0] cnt_vec_t;
  typedef struct packed {
    cnt_vec_t mx;
    cnt_vec_t al;
    cnt_vec_t nd;
    cnt_vec_t pd;
  } row_t;
  localparam int ROW_W = $bits(row_t);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_WINIT = 4'd3;
  localparam logic [3:0] S_WRD   = 4'd4;
  localparam logic [3:0] S_WCHK  = 4'd5;
  localparam logic [3:0] S_WEND  = 4'd6;
  localparam logic [3:0] S_RRD   = 4'd7;
  localparam logic [3:0] S_RCHK  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_FDATA = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  function automatic logic [COUNT_W-1:0] sat8(input logic [7:0] v);
    logic [15:0] w;
    w = 16'(v);
    return (w > 16'(CMAX)) ? CMAX : w[COUNT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] sub_sat(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [COUNT_W-1:0] add_sat(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? CMAX : s[COUNT_W-1:0];
  endfunction

  function automatic logic [7:0] low8(input logic [COUNT_W-1:0] v);
    logic [15:0] w;
    w = 16'(v);
    return w[7:0];
  endfunction

  logic [3:0]         state;
  logic [7:0]         total [brr_pkg::NRES_PORTS];
  logic [2:0]         op_q;
  logic [PW-1:0]      p_q;
  logic               pvalid_q;
  cnt_vec_t           amt_q;
  cnt_vec_t           avail;
  logic [NPROC-1:0]   waiting;
  logic [NPROC-1:0]   done;
  logic               progress;
  logic [WW-1:0]      work [NRES];
  logic [PW-1:0]      j;
  logic [CW-1:0]      i;
  logic [PW-1:0]      tgt;
  logic               retry;
  row_t               cur;
  logic [3:0]         status_q;
  logic [NRES-1:0]    refused_q;
  cnt_vec_t           alloc_q;

  logic [7:0]         amt_raw [brr_pkg::NRES_PORTS];
  logic [7:0]         proc_ext;
  logic               mem_clear;
  logic               mem_we;
  logic [PW-1:0]      mem_waddr;
  row_t               mem_wdata;
  logic [PW-1:0]      mem_raddr;
  logic [ROW_W-1:0]   mem_rdata;
  row_t               rd_row;
  row_t               ld_row;
  row_t               src_row;
  row_t               trial_row;
  row_t               rel_row;
  row_t               back_row;
  cnt_vec_t           trial_avail;
  cnt_vec_t           rel_avail;
  cnt_vec_t           back_avail;
  logic [NRES-1:0]    rel_refused;
  logic               over;
  logic               fits_avail;
  logic               fits_walk;
  logic               safe;
  logic               last_j;
  logic               accept;

  assign amt_raw[0] = amount_0;
  assign amt_raw[1] = amount_1;
  assign amt_raw[2] = amount_2;
  assign amt_raw[3] = amount_3;
  assign proc_ext   = 8'(proc);
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign rd_row     = row_t'(mem_rdata);
  assign safe       = &done;
  assign last_j     = (j == PW'(NPROC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < brr_pkg::NRES_PORTS; r++) begin
        total[r] <= '0;
      end
    end else if (cfg_we) begin
      total[cfg_index] <= cfg_data;
    end
  end

  // per-row arithmetic
  always_comb begin
    ld_row      = rd_row;
    src_row     = rd_row;
    over        = 1'b0;
    fits_avail  = 1'b1;
    fits_walk   = 1'b1;
    rel_row     = rd_row;
    rel_avail   = avail;
    rel_refused = '0;
    if (state == S_EXEC) begin
      src_row.pd = amt_q;
    end
    trial_row   = src_row;
    trial_avail = avail;
    back_row    = cur;
    back_avail  = avail;
    for (int r = 0; r < NRES; r++) begin
      ld_row.mx[r] = amt_q[r];
      ld_row.nd[r] = sub_sat(amt_q[r], rd_row.al[r]);
      if (amt_q[r] > rd_row.nd[r]) begin
        over = 1'b1;
      end
      if (src_row.pd[r] > avail[r]) begin
        fits_avail = 1'b0;
      end
      if (WW'(rd_row.nd[r]) > work[r]) begin
        fits_walk = 1'b0;
      end
      trial_row.al[r] = add_sat(src_row.al[r], src_row.pd[r]);
      trial_row.nd[r] = sub_sat(src_row.nd[r], src_row.pd[r]);
      trial_avail[r]  = sub_sat(avail[r], src_row.pd[r]);
      back_row.al[r]  = sub_sat(cur.al[r], cur.pd[r]);
      back_row.nd[r]  = add_sat(cur.nd[r], cur.pd[r]);
      back_avail[r]   = add_sat(avail[r], cur.pd[r]);
      if (amt_q[r] <= rd_row.al[r]) begin
        rel_row.al[r] = rd_row.al[r] - amt_q[r];
        rel_row.nd[r] = sub_sat(rd_row.mx[r], rd_row.al[r] - amt_q[r]);
        rel_row.pd[r] = '0;
        rel_avail[r]  = add_sat(avail[r], amt_q[r]);
      end else begin
        rel_refused[r] = 1'b1;
      end
    end
  end

  // memory port control
  always_comb begin
    mem_clear = accept && (op == brr_pkg::OP_START);
    mem_we    = 1'b0;
    mem_waddr = p_q;
    mem_wdata = rd_row;
    mem_raddr = p_q;
    unique case (state)
      S_EXEC: begin
        if (!waiting[p_q]) begin
          unique case (op_q)
            brr_pkg::OP_LOAD: begin
              mem_we    = 1'b1;
              mem_wdata = ld_row;
            end
            brr_pkg::OP_REQUEST: begin
              mem_we = 1'b1;
              if (over) begin
                mem_wdata    = rd_row;
                mem_wdata.pd = '0;
              end else if (!fits_avail) begin
                mem_wdata = src_row;
              end else begin
                mem_wdata = trial_row;
              end
            end
            default: begin
              mem_we    = 1'b1;
              mem_wdata = rel_row;
            end
          endcase
        end
      end
      S_WRD: begin
        mem_raddr = j;
      end
      S_WEND: begin
        mem_we    = 1'b1;
        mem_waddr = tgt;
        if (safe) begin
          mem_wdata    = cur;
          mem_wdata.pd = '0;
        end else begin
          mem_wdata = back_row;
        end
      end
      S_RRD: begin
        mem_raddr = i[PW-1:0];
      end
      S_RCHK: begin
        if (fits_avail) begin
          mem_we    = 1'b1;
          mem_waddr = i[PW-1:0];
          mem_wdata = trial_row;
        end
      end
      default: begin
        mem_raddr = p_q;
      end
    endcase
  end

  brr_row_mem #(
    .DEPTH(NPROC),
    .WIDTH(ROW_W),
    .AW   (PW)
  ) u_row_mem (
    .clk  (clk),
    .rst  (rst),
    .clear(mem_clear),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(ROW_W'(mem_wdata)),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      avail     <= '0;
      waiting   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= op;
            p_q       <= proc_ext[PW-1:0];
            pvalid_q  <= (6'(proc) < 6'(NPROC));
            refused_q <= '0;
            for (int r = 0; r < NRES; r++) begin
              amt_q[r] <= sat8(amt_raw[r]);
            end
            if (op == brr_pkg::OP_START) begin
              for (int r = 0; r < NRES; r++) begin
                avail[r] <= sat8(total[r]);
              end
              waiting  <= '0;
              status_q <= brr_pkg::ST_STARTED;
              state    <= S_FIN;
            end else if ((op == brr_pkg::OP_LOAD || op == brr_pkg::OP_REQUEST ||
                          op == brr_pkg::OP_RELEASE) && (6'(proc) < 6'(NPROC))) begin
              status_q <= brr_pkg::ST_QUERY;
              state    <= S_RD;
            end else begin
              status_q <= brr_pkg::ST_QUERY;
              state    <= S_FIN;
            end
          end
        end
        S_RD: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (waiting[p_q]) begin
            status_q <= brr_pkg::ST_REFUSED;
            state    <= S_FIN;
          end else begin
            unique case (op_q)
              brr_pkg::OP_LOAD: begin
                status_q <= brr_pkg::ST_LOADED;
                state    <= S_FIN;
              end
              brr_pkg::OP_REQUEST: begin
                if (over) begin
                  status_q <= brr_pkg::ST_OVERNEED;
                  state    <= S_FIN;
                end else if (!fits_avail) begin
                  status_q     <= brr_pkg::ST_SHORT;
                  waiting[p_q] <= 1'b1;
                  state        <= S_FIN;
                end else begin
                  avail <= trial_avail;
                  cur   <= trial_row;
                  tgt   <= p_q;
                  retry <= 1'b0;
                  state <= S_WINIT;
                end
              end
              default: begin
                status_q  <= brr_pkg::ST_RELEASED;
                refused_q <= rel_refused;
                avail     <= rel_avail;
                i         <= '0;
                state     <= S_RRD;
              end
            endcase
          end
        end
        S_WINIT: begin
          for (int r = 0; r < NRES; r++) begin
            work[r] <= WW'(avail[r]);
          end
          done     <= '0;
          progress <= 1'b0;
          j        <= '0;
          state    <= S_WRD;
        end
        S_WRD: begin
          if (done[j]) begin
            if (!last_j) begin
              j <= j + 1'b1;
            end else if (progress) begin
              j        <= '0;
              progress <= 1'b0;
            end else begin
              state <= S_WEND;
            end
          end else begin
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (fits_walk) begin
            for (int r = 0; r < NRES; r++) begin
              work[r] <= work[r] + WW'(rd_row.al[r]);
            end
            done[j] <= 1'b1;
          end
          if (!last_j) begin
            j     <= j + 1'b1;
            state <= S_WRD;
            if (fits_walk) begin
              progress <= 1'b1;
            end
          end else if (progress || fits_walk) begin
            j        <= '0;
            progress <= 1'b0;
            state    <= S_WRD;
          end else begin
            state <= S_WEND;
          end
        end
        S_WEND: begin
          if (safe) begin
            if (retry) begin
              waiting[tgt] <= 1'b0;
            end else begin
              status_q <= brr_pkg::ST_GRANTED;
            end
          end else begin
            avail <= back_avail;
            if (!retry) begin
              waiting[tgt] <= 1'b1;
              status_q     <= brr_pkg::ST_UNSAFE;
            end
          end
          if (retry) begin
            i     <= i + 1'b1;
            state <= S_RRD;
          end else begin
            state <= S_FIN;
          end
        end
        S_RRD: begin
          if (i == CW'(NPROC)) begin
            state <= S_FIN;
          end else if (!waiting[i[PW-1:0]]) begin
            i <= i + 1'b1;
          end else begin
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          if (fits_avail) begin
            avail <= trial_avail;
            cur   <= trial_row;
            tgt   <= i[PW-1:0];
            retry <= 1'b1;
            state <= S_WINIT;
          end else begin
            i     <= i + 1'b1;
            state <= S_RRD;
          end
        end
        S_FIN: begin
          state <= S_FDATA;
        end
        S_FDATA: begin
          alloc_q <= pvalid_q ? rd_row.al : '0;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register, loaded as the request completes
  logic [3:0]      res_status;
  logic [7:0]      res_wmask;
  logic [3:0]      res_refused;
  logic [7:0]      res_avail [brr_pkg::NRES_PORTS];
  logic [7:0]      res_alloc [brr_pkg::NRES_PORTS];

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      res_status  <= status_q;
      res_refused <= 4'(refused_q);
      for (int b = 0; b < 8; b++) begin
        res_wmask[b] <= (b < NPROC) ? waiting[b % NPROC] : 1'b0;
      end
      for (int r = 0; r < brr_pkg::NRES_PORTS; r++) begin
        res_avail[r] <= (r < NRES) ? low8(avail[r % NRES]) : 8'd0;
        res_alloc[r] <= (r < NRES) ? low8(alloc_q[r % NRES]) : 8'd0;
      end
    end
  end

  assign status               = res_status;
  assign waiting_mask         = res_wmask;
  assign release_refused_mask = res_refused;
  assign avail_0              = res_avail[0];
  assign avail_1              = res_avail[1];
  assign avail_2              = res_avail[2];
  assign avail_3              = res_avail[3];
  assign proc_alloc_0         = res_alloc[0];
  assign proc_alloc_1         = res_alloc[1];
  assign proc_alloc_2         = res_alloc[2];
  assign proc_alloc_3         = res_alloc[3];

endmodule
`default_nettype wire
